// ===== hdl/swa_pkg.sv =====
// package for the sliding window average block
// holds field widths, reset values and the sequencer state type; no dependencies
package swa_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int CFG_W              = 5;
  localparam int MAX_WINDOW_DEFAULT = 16;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 5'd10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } swa_state_t;

endpackage

// ===== hdl/sliding_window_average.sv =====
// sliding window (boxcar) average over unsigned q8.8 samples
// depends on swa_pkg; ring of samples kept in an internal synchronous memory
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  sample    | sample_valid / sample_stall  | sample[15:0], end_of_block
//  average   | average_valid / average_stall| average[15:0], last_average
//  config    | window_len_we                | window_len[4:0]
//
// a request without a result passes through accept, then ring read and sum update
// a request with a result goes on through the bit-serial divider, which works through
//   the sum one bit at a time, and then through the output hand-off
// one request is in flight at a time; the ring read state exists for the registered ring memory read
// rst is synchronous, active high; the ring itself is not cleared
// a finished result waits in the hand-off state while an earlier one is stalled,
//   and the sample channel stays stalled until average_stall drops
module sliding_window_average
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                window_len_we,
  input  logic [CFG_W-1:0]    window_len,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                end_of_block,
  output logic                average_valid,
  input  logic                average_stall,
  output logic [SAMPLE_W-1:0] average,
  output logic                last_average
);

  // ring index, window length and sum widths all follow from the ring depth
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(SUM_W + 1);

  // sample history, one write and one read port
  logic [SAMPLE_W-1:0] ring [0:MAX_WINDOW-1];
  logic [SAMPLE_W-1:0] ring_rd;

  swa_state_t          state;
  logic [CFG_W-1:0]    len_raw;
  logic [IDX_W-1:0]    write_slot;
  logic [LEN_W-1:0]    fill_count;
  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] sample_r;
  logic                eob_r;

  // divider registers
  logic [SUM_W-1:0]    div_num;
  logic [LEN_W-1:0]    div_rem;
  logic [LEN_W-1:0]    div_den;
  logic [CNT_W-1:0]    div_cnt;
  logic                div_last;

  logic [LEN_W-1:0]    eff_len;
  logic [EXT_W-1:0]    len_ext;
  logic [LEN_W-1:0]    slot_ext;
  logic [LEN_W-1:0]    old_pos;
  logic [IDX_W-1:0]    old_idx;
  logic                accept;
  logic                full_window;
  logic [LEN_W-1:0]    fill_next;
  logic [SUM_W-1:0]    sum_next;
  logic                has_result;
  logic [LEN_W:0]      rem_shift;
  logic                rem_ge;
  logic [LEN_W-1:0]    rem_next;
  logic                out_free;

  // zero acts as one, anything above the ring depth as the ring depth
  always_comb begin
    len_ext = EXT_W'(len_raw);
    if (len_raw == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > EXT_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[LEN_W-1:0];
    end
  end

  // slot of the sample leaving the window
  always_comb begin
    slot_ext = LEN_W'(write_slot);
    if (slot_ext >= eff_len) begin
      old_pos = slot_ext - eff_len;
    end else begin
      old_pos = slot_ext + LEN_W'(MAX_WINDOW) - eff_len;
    end
    old_idx = old_pos[IDX_W-1:0];
  end

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !average_valid || !average_stall;

  // running sum update, evaluated in the read cycle when ring_rd is valid
  always_comb begin
    full_window = (fill_count >= eff_len);
    if (full_window) begin
      fill_next = fill_count;
      sum_next  = window_sum - SUM_W'(ring_rd) + SUM_W'(sample_r);
    end else begin
      fill_next = fill_count + LEN_W'(1);
      sum_next  = window_sum + SUM_W'(sample_r);
    end
    has_result = (fill_next >= eff_len);
  end

  // one restoring division step
  always_comb begin
    rem_shift = {div_rem, div_num[SUM_W-1]};
    rem_ge    = (rem_shift >= {1'b0, div_den});
    if (rem_ge) begin
      rem_next = LEN_W'(rem_shift - {1'b0, div_den});
    end else begin
      rem_next = rem_shift[LEN_W-1:0];
    end
    div_last = (div_cnt == CNT_W'(SUM_W - 1));
  end

  // ring memory: registered read at accept, write-back in the read cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= ring[old_idx];
    end
    if (state == ST_READ) begin
      ring[write_slot] <= sample_r;
    end
  end

  // request payload and divider datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
      eob_r    <= end_of_block;
    end
    case (state)
      ST_READ: begin
        div_num <= sum_next;
        div_rem <= '0;
        div_den <= eff_len;
        div_cnt <= '0;
      end
      ST_DIV: begin
        div_num <= {div_num[SUM_W-2:0], rem_ge};
        div_rem <= rem_next;
        div_cnt <= div_cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      len_raw       <= WINDOW_LEN_RESET;
      write_slot    <= '0;
      fill_count    <= '0;
      window_sum    <= '0;
      average_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          write_slot <= (write_slot == IDX_W'(MAX_WINDOW - 1)) ? '0 :
                        write_slot + IDX_W'(1);
          // end of block or a new window length restarts the window after this request
          if (eob_r || window_len_we) begin
            fill_count <= '0;
            window_sum <= '0;
          end else begin
            fill_count <= fill_next;
            window_sum <= sum_next;
          end
          state <= has_result ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_last) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // result valid: raised at the hand-off, dropped once taken
      if (state == ST_HOLD && out_free) begin
        average_valid <= 1'b1;
      end else if (average_valid && !average_stall) begin
        average_valid <= 1'b0;
      end
      // a new window length restarts the block
      if (window_len_we) begin
        len_raw <= window_len;
        if (state != ST_READ) begin
          fill_count <= '0;
          window_sum <= '0;
        end
      end
    end
  end

  // result payload, loaded with the valid flag
  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      average      <= div_num[SAMPLE_W-1:0];
      last_average <= eob_r;
    end
  end

  a_accept_reads : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted request did not move to ring read");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> fill_count <= eff_len)
    else $error("fill count beyond window length");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> (div_rem < div_den) && (div_cnt < CNT_W'(SUM_W)))
    else $error("divider remainder or step count out of range");

  a_result_from_hold : assert property (@(posedge clk) disable iff (rst)
    $rose(average_valid) |-> $past(state == ST_HOLD))
    else $error("result raised outside the hand-off state");

endmodule

// ===== tb/sv/sliding_window_average_tb.sv =====
// self-checking testbench for the sliding window average block
// depends on swa_pkg and sliding_window_average; predicts each window mean in the bench
`timescale 1ns / 100ps

module sliding_window_average_tb
  import swa_pkg::*;
();

  localparam int RING_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 40;       // longer than the divide path and hand-off
  localparam int HOLD_CYCLES   = 300;      // receiver hold-off in the backpressure test
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                closes_block;
  } average_t;

  logic                clk;
  logic                rst;
  logic                window_len_we;
  logic [CFG_W-1:0]    window_len;
  logic                sample_valid;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample;
  logic                end_of_block;
  logic                average_valid;
  logic                average_stall;
  logic [SAMPLE_W-1:0] average;
  logic                last_average;

  // bench copy of the block state
  logic [SAMPLE_W-1:0] history [RING_DEPTH];
  logic [3:0]          next_slot;
  int unsigned         samples_in_block;
  logic [19:0]         running_sum;
  logic [CFG_W-1:0]    len_setting;

  average_t expected_averages [$];

  int error_count = 0;
  int samples_sent;
  int averages_checked = 0;
  int lengths_written;
  int cycle_count = 0;
  int hold_requests;
  int holds_done = 0;
  bit sender_idle;
  bit receiver_idle;

  sliding_window_average DUT (
    .clk           (clk),
    .rst           (rst),
    .window_len_we (window_len_we),
    .window_len    (window_len),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .end_of_block  (end_of_block),
    .average_valid (average_valid),
    .average_stall (average_stall),
    .average       (average),
    .last_average  (last_average)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // zero acts as one, anything past the ring depth acts as the ring depth
  function automatic int unsigned effective_window(input logic [CFG_W-1:0] code);
    if (code == 0) return 1;
    if (code > RING_DEPTH) return RING_DEPTH;
    return 32'(code);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // advance the bench state by one accepted request, queue its mean if the window is full
  function automatic void update_window_average(input logic [SAMPLE_W-1:0] value,
                                                input logic eob);
    int unsigned span;
    logic [3:0]  oldest;
    average_t    result;
    span = effective_window(len_setting);
    if (samples_in_block >= span) begin
      oldest = next_slot - 4'(span);   // wraps mod ring depth, span 16 lands on next_slot
      running_sum = running_sum - 20'(history[oldest]);
    end else begin
      samples_in_block++;
    end
    running_sum = running_sum + 20'(value);
    history[next_slot] = value;
    next_slot = next_slot + 4'd1;
    if (samples_in_block >= span) begin
      result.mean = SAMPLE_W'(running_sum / span);
      result.closes_block = eob;
      expected_averages = {expected_averages, result};
    end
    if (eob) begin
      samples_in_block = 0;
      running_sum = '0;
    end
  endfunction

  // one request on the sample channel; valid stays high for a back-to-back follower
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic eob);
    int gap;
    gap = sender_idle ? idle_gap() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    end_of_block <= eob;
    do @(posedge clk); while (sample_stall);
    update_window_average(value, eob);
    samples_sent++;
  endtask

  // no requests in flight and nothing outstanding, plus room for a request without result
  task automatic wait_until_idle();
    sample_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] code);
    wait_until_idle();
    window_len_we <= 1'b1;
    window_len <= code;
    @(posedge clk);
    window_len_we <= 1'b0;
    len_setting = code;
    samples_in_block = 0;
    running_sum = '0;
    lengths_written++;
  endtask

  // reset length of 10: a short block gives nothing, then a partial block left open
  task automatic test_short_block_at_reset_length();
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    repeat (5) send_sample(random_sample(), 1'b0);
  endtask

  // the length write must drop the open block; oversized code acts as a full ring
  task automatic test_length_write_restarts_block();
    write_window_len(5'd31);
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_sample(16'hffff, i == RING_DEPTH - 1);
    end
  endtask

  // zero acts as one: every request gives its own sample back
  task automatic test_zero_length();
    write_window_len(5'd0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] code, input int quota);
    int unsigned span;
    int          sent;
    int          kind;
    int          block_len;
    bit          closed;
    write_window_len(code);
    span = effective_window(code);
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(9);
      closed = 1'b1;
      if (kind < 7) begin
        block_len = $urandom_range(span, span + 24);
      end else if (kind < 9) begin
        block_len = (span > 1) ? $urandom_range(1, span - 1) : 1;
      end else begin
        block_len = $urandom_range(1, 40);
        closed = 1'b0;     // block runs on into the next one
      end
      for (int i = 0; i < block_len; i++) begin
        send_sample(random_sample(), closed && (i == block_len - 1));
      end
      sent += block_len;
    end
  endtask

  task automatic test_random_blocks();
    logic [CFG_W-1:0] codes [9];
    codes = '{5'd10, 5'd1, 5'd16, 5'd2, 5'd17, 5'd31, 5'd0,
              CFG_W'($urandom_range(3, 15)), CFG_W'($urandom_range(0, 31))};
    for (int p = 0; p < 9; p++) begin
      sender_idle   = (p % 4 == 0) || (p % 4 == 1);
      receiver_idle = (p % 4 == 0) || (p % 4 == 2);
      run_random_phase(codes[p], 100);
    end
  endtask

  // receiver holds off while requests keep coming, so the block must stall its input
  task automatic test_output_backpressure();
    write_window_len(5'd4);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_requests++;
    for (int i = 0; i < 48; i++) begin
      send_sample(random_sample(), (i % 12) == 11);
    end
  endtask

  // receiver side: long hold on request, otherwise random stall stretches
  initial begin : receiver_stall
    int stretch;
    int held;
    average_stall <= 1'b0;
    stretch = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (held > 0) begin
        held--;
        average_stall <= 1'b1;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        held = HOLD_CYCLES - 1;
        average_stall <= 1'b1;
      end else if (stretch > 0) begin
        stretch--;
        average_stall <= 1'b1;
      end else begin
        stretch = receiver_idle ? idle_gap() : 0;
        if (stretch > 0) begin
          stretch--;
          average_stall <= 1'b1;
        end else begin
          average_stall <= 1'b0;
        end
      end
    end
  end

  // compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    average_t want;
    if (!rst && average_valid === 1'b1 && !average_stall) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected average %h last %b", $time, average, last_average);
        error_count++;
      end else begin
        want = expected_averages.pop_front();
        averages_checked++;
        if (average !== want.mean) begin
          $display("%0t: average mismatch expected %h actual %h", $time, want.mean, average);
          error_count++;
        end
        if (last_average !== want.closes_block) begin
          $display("%0t: last_average mismatch expected %b actual %b",
                   $time, want.closes_block, last_average);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int waited;
    bit leftovers;
    rst           <= 1'b1;
    window_len_we <= 1'b0;
    window_len    <= '0;
    sample_valid  <= 1'b0;
    sample        <= '0;
    end_of_block  <= 1'b0;
    samples_sent  = 0;
    lengths_written  = 0;
    hold_requests = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    next_slot     = '0;
    samples_in_block = 0;
    running_sum   = '0;
    len_setting   = WINDOW_LEN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_block_at_reset_length();
    test_length_write_restarts_block();
    test_zero_length();
    test_random_blocks();
    test_output_backpressure();

    sample_valid <= 1'b0;
    waited = 0;
    while (expected_averages.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftovers = (expected_averages.size() != 0);
    if (leftovers) begin
      $display("%0t: %0d expected averages never arrived", $time, expected_averages.size());
    end

    $display("sent %0d samples over %0d window length writes, checked %0d averages",
             samples_sent, lengths_written, averages_checked);
    $display("receiver held off %0d cycles once with the sample channel kept busy",
             HOLD_CYCLES);
    if (error_count == 0 && !leftovers) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/swa_pkg.sv
hdl/sliding_window_average.sv
tb/sv/sliding_window_average_tb.sv
